### design/usf_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the UV sphere face generator.
`default_nettype none

package usf_pkg;

  localparam int MaxResolutionDefault = 256;
  localparam int TrigStagesDefault    = 16;

  localparam int FaceW   = 17;  // face index
  localparam int ResW    = 9;   // resolution, row and column index
  localparam int CoordW  = 16;  // output coordinate
  localparam int PhaseW  = 32;  // angle, fraction of a full turn
  localparam int TrigW   = 32;  // Q30 sine and cosine
  localparam int AtanW   = 30;
  localparam int CoordsPerFace = 9;
  localparam int FifoDepth     = 2;

  localparam logic [AtanW-1:0]         CordicGain = 30'd652032874;
  localparam logic signed [CoordW-1:0] UnitOut    = 16'sd16384;

  typedef enum logic [1:0] {
    FaceMesh       = 2'd0,
    FaceFiller     = 2'd1,
    FaceOutOfRange = 2'd2
  } face_status_e;

  typedef enum logic [1:0] {
    CfgResAround = 2'd0,
    CfgResDown   = 2'd1
  } cfg_reg_e;

  // One classified request handed from the front to the back.
  typedef struct packed {
    face_status_e    status;
    logic            odd;
    logic [ResW-1:0] row;
    logic [ResW-1:0] col;
  } usf_item_t;

  // atan(2^-k) in units of 2^32 per turn.
  function automatic logic [AtanW-1:0] atan_turn(input int unsigned k);
    logic [AtanW-1:0] v;
    case (k)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/usf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module usf_div #(
  parameter int NW = 16,
  parameter int DW = 9,
  parameter int QW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o,
  output logic      [DW-1:0] rem_o
);

  localparam int WW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0] rin;
    logic [QW-1:0] qin;
    logic [WW-1:0] rext;
    logic [WW-1:0] trial;
    logic          fits;

    if (s == 0) begin : g_first
      assign rin = num_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign qin = quo_q[s-1];
    end

    assign rext  = WW'(rin);
    assign trial = WW'(den_i) << (QW - 1 - s);
    assign fits  = (rext >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= fits ? NW'(rext - trial) : rin;
        quo_q[s] <= qin | (fits ? (QW'(1) << (QW - 1 - s)) : QW'(0));
      end
    end
  end

  assign quo_o = quo_q[QW-1];
  assign rem_o = rem_q[QW-1][DW-1:0];

endmodule

`default_nettype wire

### design/usf_cordic.sv
// Pipelined rotation CORDIC: quadrant fold, one iteration per stage, quadrant unfold.
`default_nettype none

module usf_cordic #(
  parameter int STAGES = usf_pkg::TrigStagesDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic        [usf_pkg::PhaseW-1:0] phase_i,
  output logic signed      [usf_pkg::TrigW-1:0]  cos_o,
  output logic signed      [usf_pkg::TrigW-1:0]  sin_o
);

  localparam int CW = 34;
  localparam int ZW = 33;

  logic signed [CW-1:0] x_q [STAGES+1];
  logic signed [CW-1:0] y_q [STAGES+1];
  logic signed [ZW-1:0] z_q [STAGES+1];
  logic        [1:0]    q_q [STAGES+1];

  logic [usf_pkg::PhaseW-1:0] rounded;
  logic [usf_pkg::PhaseW-1:0] resid;
  logic [1:0]                 quad;

  assign rounded = phase_i + 32'h2000_0000;
  assign quad    = rounded[31:30];
  assign resid   = phase_i - {quad, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= $signed({4'd0, usf_pkg::CordicGain});
      y_q[0] <= '0;
      z_q[0] <= $signed({resid[31], resid});
      q_q[0] <= quad;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_iter
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] at;

    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;
    assign at = $signed({3'b000, usf_pkg::atan_turn(k)});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][ZW-1]) begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - at;
        end else begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + at;
        end
        q_q[k+1] <= q_q[k];
      end
    end
  end

  logic signed [CW-1:0] c_d;
  logic signed [CW-1:0] s_d;

  always_comb begin
    case (q_q[STAGES])
      2'd0: begin
        c_d = x_q[STAGES];
        s_d = y_q[STAGES];
      end
      2'd1: begin
        c_d = -y_q[STAGES];
        s_d = x_q[STAGES];
      end
      2'd2: begin
        c_d = -x_q[STAGES];
        s_d = -y_q[STAGES];
      end
      default: begin
        c_d = y_q[STAGES];
        s_d = -x_q[STAGES];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= c_d[usf_pkg::TrigW-1:0];
      sin_o <= s_d[usf_pkg::TrigW-1:0];
    end
  end

endmodule

`default_nettype wire

### design/usf_front.sv
// Front end: takes requests, classifies them and splits the face index into row and column.
`default_nettype none

module usf_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [usf_pkg::FaceW-1:0]      face_number_i,
  input  wire logic [usf_pkg::ResW-1:0]       res_i,
  input  wire logic [usf_pkg::ResW-1:0]       dm1_i,
  output logic                                item_valid_o,
  output usf_pkg::usf_item_t                  item_o,
  input  wire logic                           queue_full_i
);

  localparam int Lat = usf_pkg::ResW;
  localparam int KW  = usf_pkg::FaceW - 1;

  logic fen;

  logic                       s0_vld_q;
  usf_pkg::face_status_e      s0_status_q;
  logic                       s0_odd_q;
  logic [KW-1:0]              s0_k_q;

  logic [Lat-1:0]             vld_q;
  usf_pkg::face_status_e      status_q [Lat];
  logic                       odd_q    [Lat];

  logic [17:0]                rd1;
  logic [18:0]                mesh;
  logic [18:0]                total;
  logic [18:0]                nx;
  usf_pkg::face_status_e      status_d;

  logic [usf_pkg::ResW-1:0]   row;
  logic [usf_pkg::ResW-1:0]   col;

  assign fen        = !vld_q[Lat-1] || !queue_full_i;
  assign in_ready_o = fen;

  // Mesh faces fill 2*R*(D-1) slots, filler faces the next 2*R.
  assign rd1   = 18'(res_i) * 18'(dm1_i);
  assign mesh  = {rd1, 1'b0};
  assign total = mesh + 19'({res_i, 1'b0});
  assign nx    = 19'(face_number_i);

  always_comb begin
    if (nx < mesh) begin
      status_d = usf_pkg::FaceMesh;
    end else if (nx < total) begin
      status_d = usf_pkg::FaceFiller;
    end else begin
      status_d = usf_pkg::FaceOutOfRange;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      vld_q    <= '0;
    end else if (fen) begin
      s0_vld_q <= in_valid_i;
      vld_q    <= {vld_q[Lat-2:0], s0_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      s0_status_q <= status_d;
      s0_odd_q    <= face_number_i[0];
      s0_k_q      <= face_number_i[usf_pkg::FaceW-1:1];
      status_q[0] <= s0_status_q;
      odd_q[0]    <= s0_odd_q;
      for (int s = 1; s < Lat; s++) begin
        status_q[s] <= status_q[s-1];
        odd_q[s]    <= odd_q[s-1];
      end
    end
  end

  usf_div #(
    .NW(KW),
    .DW(usf_pkg::ResW),
    .QW(usf_pkg::ResW)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (fen),
    .num_i (s0_k_q),
    .den_i (res_i),
    .quo_o (row),
    .rem_o (col)
  );

  assign item_valid_o  = vld_q[Lat-1];
  assign item_o.status = status_q[Lat-1];
  assign item_o.odd    = odd_q[Lat-1];
  assign item_o.row    = row;
  assign item_o.col    = col;

endmodule

`default_nettype wire

### design/usf_fifo.sv
// Two-entry queue between the front and the back.
`default_nettype none

module usf_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_valid_i,
  input  usf_pkg::usf_item_t      wr_item_i,
  output logic                    full_o,
  input  wire logic               rd_pop_i,
  output logic                    rd_valid_o,
  output usf_pkg::usf_item_t      rd_item_o
);

  localparam int PW = $clog2(usf_pkg::FifoDepth);
  localparam int CntW = $clog2(usf_pkg::FifoDepth + 1);

  usf_pkg::usf_item_t mem_q [usf_pkg::FifoDepth];
  logic [PW-1:0]      wr_ptr_q;
  logic [PW-1:0]      rd_ptr_q;
  logic [CntW-1:0]    cnt_q;
  logic               push;
  logic               pop;

  assign full_o     = (cnt_q == CntW'(usf_pkg::FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && !full_o;
  assign pop        = rd_pop_i && rd_valid_o;
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

### design/usf_back.sv
// Back end: phase division, sine/cosine, products and rounding into the output register.
`default_nettype none

module usf_back #(
  parameter int TRIG_STAGES = usf_pkg::TrigStagesDefault
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [usf_pkg::ResW-1:0]               res_i,
  input  wire logic [usf_pkg::ResW-1:0]               dm1_i,
  input  wire logic                                   item_valid_i,
  input  usf_pkg::usf_item_t                          item_i,
  output logic                                        item_pop_o,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [1:0]                                  status_o,
  output logic [usf_pkg::CoordsPerFace-1:0][usf_pkg::CoordW-1:0] coord_o
);

  localparam int NW  = usf_pkg::PhaseW + usf_pkg::ResW;
  localparam int DW  = usf_pkg::ResW + 1;
  localparam int MD  = usf_pkg::PhaseW + TRIG_STAGES + 2;
  localparam int TW  = usf_pkg::TrigW;
  localparam int PRW = 2 * usf_pkg::TrigW;

  logic ben;

  // prep stage
  logic                        b0_vld_q;
  usf_pkg::face_status_e       b0_status_q;
  logic                        b0_odd_q;
  logic [usf_pkg::ResW-1:0]    b0_col_q;
  logic [usf_pkg::ResW-1:0]    b0_coln_q;
  logic [usf_pkg::ResW-1:0]    b0_row_q;
  logic [usf_pkg::ResW-1:0]    b0_rown_q;
  logic [usf_pkg::ResW:0]      col_inc;

  // status carried alongside the datapath
  logic [MD-1:0]               md_vld_q;
  usf_pkg::face_status_e       md_status_q [MD];
  logic                        md_odd_q    [MD];

  logic [NW-1:0] num_col;
  logic [NW-1:0] num_coln;
  logic [NW-1:0] num_row;
  logic [NW-1:0] num_rown;
  logic [DW-1:0] den_col;
  logic [DW-1:0] den_row;
  logic [usf_pkg::PhaseW-1:0] ph_col;
  logic [usf_pkg::PhaseW-1:0] ph_coln;
  logic [usf_pkg::PhaseW-1:0] ph_row;
  logic [usf_pkg::PhaseW-1:0] ph_rown;
  logic [DW-1:0] rem_col;
  logic [DW-1:0] rem_coln;
  logic [DW-1:0] rem_row;
  logic [DW-1:0] rem_rown;

  logic signed [TW-1:0] ca_j, sa_j, ca_n, sa_n, cb_i, sb_i, cb_n, sb_n;

  // multiply stage
  logic                   m_vld_q;
  usf_pkg::face_status_e  m_status_q;
  logic signed [PRW-1:0]  px_q [3];
  logic signed [PRW-1:0]  pz_q [3];
  logic signed [TW-1:0]   cy_q [3];
  logic signed [TW-1:0]   sa1, ca1, sb1, sb3, cb1, cb3;

  // rounding
  logic signed [PRW-1:0]  rnd_x [3];
  logic signed [PRW-1:0]  rnd_z [3];
  logic signed [TW:0]     rnd_y [3];

  // output register
  logic                   out_vld_q;
  usf_pkg::face_status_e  out_status_q;
  logic [usf_pkg::CoordsPerFace-1:0][usf_pkg::CoordW-1:0] out_coord_q;
  logic [usf_pkg::CoordsPerFace-1:0][usf_pkg::CoordW-1:0] coord_d;

  assign ben        = !out_vld_q || out_ready_i;
  assign item_pop_o = ben && item_valid_i;

  assign col_inc = {1'b0, item_i.col} + 10'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_vld_q  <= 1'b0;
      md_vld_q  <= '0;
      m_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (ben) begin
      b0_vld_q  <= item_valid_i;
      md_vld_q  <= {md_vld_q[MD-2:0], b0_vld_q};
      m_vld_q   <= md_vld_q[MD-1];
      out_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      b0_status_q <= item_i.status;
      b0_odd_q    <= item_i.odd;
      b0_col_q    <= item_i.col;
      b0_coln_q   <= (col_inc == {1'b0, res_i}) ? '0 : col_inc[usf_pkg::ResW-1:0];
      b0_row_q    <= item_i.row;
      b0_rown_q   <= item_i.row + usf_pkg::ResW'(1);
      md_status_q[0] <= b0_status_q;
      md_odd_q[0]    <= b0_odd_q;
      for (int s = 1; s < MD; s++) begin
        md_status_q[s] <= md_status_q[s-1];
        md_odd_q[s]    <= md_odd_q[s-1];
      end
    end
  end

  // phase = round(col * 2^32 / R) and round(row * 2^32 / (2 * (D - 1)))
  assign den_col  = {1'b0, res_i};
  assign den_row  = {dm1_i, 1'b0};
  assign num_col  = {b0_col_q, 32'd0} + NW'(res_i >> 1);
  assign num_coln = {b0_coln_q, 32'd0} + NW'(res_i >> 1);
  assign num_row  = {b0_row_q, 32'd0} + NW'(dm1_i);
  assign num_rown = {b0_rown_q, 32'd0} + NW'(dm1_i);

  usf_div #(.NW(NW), .DW(DW), .QW(usf_pkg::PhaseW)) u_div_col (
    .clk_i (clk_i), .en_i (ben), .num_i (num_col), .den_i (den_col),
    .quo_o (ph_col), .rem_o (rem_col)
  );
  usf_div #(.NW(NW), .DW(DW), .QW(usf_pkg::PhaseW)) u_div_coln (
    .clk_i (clk_i), .en_i (ben), .num_i (num_coln), .den_i (den_col),
    .quo_o (ph_coln), .rem_o (rem_coln)
  );
  usf_div #(.NW(NW), .DW(DW), .QW(usf_pkg::PhaseW)) u_div_row (
    .clk_i (clk_i), .en_i (ben), .num_i (num_row), .den_i (den_row),
    .quo_o (ph_row), .rem_o (rem_row)
  );
  usf_div #(.NW(NW), .DW(DW), .QW(usf_pkg::PhaseW)) u_div_rown (
    .clk_i (clk_i), .en_i (ben), .num_i (num_rown), .den_i (den_row),
    .quo_o (ph_rown), .rem_o (rem_rown)
  );

  usf_cordic #(.STAGES(TRIG_STAGES)) u_trig_col (
    .clk_i (clk_i), .en_i (ben), .phase_i (ph_col), .cos_o (ca_j), .sin_o (sa_j)
  );
  usf_cordic #(.STAGES(TRIG_STAGES)) u_trig_coln (
    .clk_i (clk_i), .en_i (ben), .phase_i (ph_coln), .cos_o (ca_n), .sin_o (sa_n)
  );
  usf_cordic #(.STAGES(TRIG_STAGES)) u_trig_row (
    .clk_i (clk_i), .en_i (ben), .phase_i (ph_row), .cos_o (cb_i), .sin_o (sb_i)
  );
  usf_cordic #(.STAGES(TRIG_STAGES)) u_trig_rown (
    .clk_i (clk_i), .en_i (ben), .phase_i (ph_rown), .cos_o (cb_n), .sin_o (sb_n)
  );

  // even: (i,j) (i+1,j) (i,j+1); odd: (i,j+1) (i+1,j) (i+1,j+1)
  assign sa1 = md_odd_q[MD-1] ? sa_n : sa_j;
  assign ca1 = md_odd_q[MD-1] ? ca_n : ca_j;
  assign sb1 = sb_i;
  assign cb1 = cb_i;
  assign sb3 = md_odd_q[MD-1] ? sb_n : sb_i;
  assign cb3 = md_odd_q[MD-1] ? cb_n : cb_i;

  always_ff @(posedge clk_i) begin
    if (ben) begin
      m_status_q <= md_status_q[MD-1];
      px_q[0] <= sa1 * sb1;
      pz_q[0] <= ca1 * sb1;
      cy_q[0] <= cb1;
      px_q[1] <= sa_j * sb_n;
      pz_q[1] <= ca_j * sb_n;
      cy_q[1] <= cb_n;
      px_q[2] <= sa_n * sb3;
      pz_q[2] <= ca_n * sb3;
      cy_q[2] <= cb3;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd_x[c] = px_q[c] + (64'sd1 <<< 46);
      rnd_z[c] = pz_q[c] + (64'sd1 <<< 46);
      rnd_y[c] = {cy_q[c][TW-1], cy_q[c]} + 33'sd65536;
      case (m_status_q)
        usf_pkg::FaceMesh: begin
          coord_d[3*c]   = rnd_x[c][62:47];
          coord_d[3*c+1] = rnd_y[c][TW:17];
          coord_d[3*c+2] = rnd_z[c][62:47];
        end
        usf_pkg::FaceFiller: begin
          coord_d[3*c]   = usf_pkg::UnitOut;
          coord_d[3*c+1] = usf_pkg::UnitOut;
          coord_d[3*c+2] = usf_pkg::UnitOut;
        end
        default: begin
          coord_d[3*c]   = '0;
          coord_d[3*c+1] = '0;
          coord_d[3*c+2] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      out_status_q <= m_status_q;
      out_coord_q  <= coord_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_status_q;
  assign coord_o     = out_coord_q;

endmodule

`default_nettype wire

### design/uv_sphere_face_generator.sv
// Top level of the UV sphere face generator: config registers, front, queue and back.
//
// Usage:
//   Face requests enter on in_valid_i/in_ready_o with face_number_i; each gives one
//   result on out_valid_o/out_ready_i: face_status_o and the three corners
//   (first_*, second_*, third_*), 16384 = 1.0, on a sphere of radius one half.
//   Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
//   cfg_data_i: index 0 is res_around, index 1 is res_down, others are ignored.
//   cfg_ready_o is always high; write only while no request is in flight.
//   From acceptance to out_valid_o a request passes the 9-stage index divider,
//   the 32-stage phase dividers and the TRIG_STAGES + 2 stage CORDICs.
//   Throughput: one face per cycle while out_ready_i does not stall the output.
//   Reset clears all valid state and sets both resolutions to 16.
//   When the receiver stalls, the back end holds in place with its result in
//   the output register; the front keeps taking requests until the two-entry
//   queue and its own pipeline fill, then drops in_ready_o.
`default_nettype none

module uv_sphere_face_generator #(
  parameter int MAX_RESOLUTION = usf_pkg::MaxResolutionDefault,
  parameter int TRIG_STAGES    = usf_pkg::TrigStagesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [16:0] face_number_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       face_status_o,
  output logic [15:0]      first_x_o,
  output logic [15:0]      first_y_o,
  output logic [15:0]      first_z_o,
  output logic [15:0]      second_x_o,
  output logic [15:0]      second_y_o,
  output logic [15:0]      second_z_o,
  output logic [15:0]      third_x_o,
  output logic [15:0]      third_y_o,
  output logic [15:0]      third_z_o
);

  localparam logic [10:0] MaxRes = 11'(MAX_RESOLUTION);

  logic [usf_pkg::ResW-1:0] res_around_q;
  logic [usf_pkg::ResW-1:0] res_down_q;
  logic [usf_pkg::ResW-1:0] res;
  logic [usf_pkg::ResW-1:0] rdown;
  logic [usf_pkg::ResW-1:0] dm1;

  logic                     f_valid;
  usf_pkg::usf_item_t       f_item;
  logic                     q_full;
  logic                     q_valid;
  usf_pkg::usf_item_t       q_item;
  logic                     q_pop;
  logic [usf_pkg::CoordsPerFace-1:0][usf_pkg::CoordW-1:0] coord;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_around_q <= 9'd16;
      res_down_q   <= 9'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        usf_pkg::CfgResAround: res_around_q <= cfg_data_i;
        usf_pkg::CfgResDown:   res_down_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate the stored resolutions where they are used.
  always_comb begin
    if (res_around_q < 9'd3) begin
      res = 9'd3;
    end else if ({2'b00, res_around_q} > MaxRes) begin
      res = MaxRes[usf_pkg::ResW-1:0];
    end else begin
      res = res_around_q;
    end
    if (res_down_q < 9'd2) begin
      rdown = 9'd2;
    end else if ({2'b00, res_down_q} > MaxRes) begin
      rdown = MaxRes[usf_pkg::ResW-1:0];
    end else begin
      rdown = res_down_q;
    end
  end

  assign dm1 = rdown - 9'd1;

  usf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .face_number_i (face_number_i),
    .res_i         (res),
    .dm1_i         (dm1),
    .item_valid_o  (f_valid),
    .item_o        (f_item),
    .queue_full_i  (q_full)
  );

  usf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_item_i  (f_item),
    .full_o     (q_full),
    .rd_pop_i   (q_pop),
    .rd_valid_o (q_valid),
    .rd_item_o  (q_item)
  );

  usf_back #(
    .TRIG_STAGES (TRIG_STAGES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .dm1_i        (dm1),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (face_status_o),
    .coord_o      (coord)
  );

  assign first_x_o  = coord[0];
  assign first_y_o  = coord[1];
  assign first_z_o  = coord[2];
  assign second_x_o = coord[3];
  assign second_y_o = coord[4];
  assign second_z_o = coord[5];
  assign third_x_o  = coord[6];
  assign third_y_o  = coord[7];
  assign third_z_o  = coord[8];

`ifndef SYNTHESIS
  // Filler faces sit at (1,1,1).
  a_filler_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && face_status_o == usf_pkg::FaceFiller) |->
      (first_x_o == 16'd16384 && second_y_o == 16'd16384 && third_z_o == 16'd16384))
    else $error("filler face not at unit corner");

  // Out-of-range requests give zero coordinates.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && face_status_o == usf_pkg::FaceOutOfRange) |->
      (first_x_o == 16'd0 && second_y_o == 16'd0 && third_z_o == 16'd0))
    else $error("out-of-range face with nonzero coordinates");

  // Mesh heights stay on a sphere of radius one half.
  a_mesh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && face_status_o == usf_pkg::FaceMesh) |->
      ($signed(first_y_o) <= 16'sd8200 && $signed(first_y_o) >= -16'sd8200))
    else $error("mesh vertex outside sphere");
`endif

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for the UV sphere face generator: directed and random faces against a built-in predictor.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxRes = 256;
  localparam int TrigStages = 16;
  localparam int DrainCycles = 120;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    usf_pkg::face_status_e status;
    logic [8:0][15:0] coord;              // first_x .. third_z, index 8 first
  } face_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  usf_pkg::cfg_reg_e cfg_index = usf_pkg::CfgResAround;
  logic [8:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [16:0] face_number = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] face_status;
  logic [15:0] fx, fy, fz, sx, sy, sz, tx, ty, tz;
  logic hold_tx = 1'b0;

  // Settings mirrored by the predictor.
  logic [8:0] around_q = 9'd16;
  logic [8:0] down_q = 9'd16;

  face_t expected_faces[$];
  logic [16:0] pending_faces[$];
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int errors = 0;
  int faces_checked = 0;
  int filler_seen = 0;
  int range_seen = 0;
  int cycles = 0;

  always #4 clk = ~clk;

  uv_sphere_face_generator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .face_number_i(face_number),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .face_status_o(face_status),
    .first_x_o(fx), .first_y_o(fy), .first_z_o(fz),
    .second_x_o(sx), .second_y_o(sy), .second_z_o(sz),
    .third_x_o(tx), .third_y_o(ty), .third_z_o(tz)
  );

  // Arithmetic shift right with floor semantics.
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation-mode CORDIC on a 2^32-per-turn phase; returns cos and sin in Q30.
  function automatic void cordic_sincos(logic [31:0] phase, output longint c,
                                        output longint s);
    logic [31:0] quad, resid;
    longint zr, xr, yr, nx;
    quad = ((phase + 32'h2000_0000) >> 30) & 32'd3;
    resid = phase - (quad << 30);
    zr = resid[31] ? longint'(resid) - 64'sd4294967296 : longint'(resid);
    xr = 652032874;
    yr = 0;
    for (int k = 0; k < TrigStages; k++) begin
      if (zr >= 0) begin
        nx = xr - sra(yr, k);
        yr = yr + sra(xr, k);
        zr = zr - longint'(usf_pkg::atan_turn(k));
      end else begin
        nx = xr + sra(yr, k);
        yr = yr - sra(xr, k);
        zr = zr + longint'(usf_pkg::atan_turn(k));
      end
      xr = nx;
    end
    case (quad[1:0])
      2'd0: begin c = xr; s = yr; end
      2'd1: begin c = -yr; s = xr; end
      2'd2: begin c = -xr; s = -yr; end
      default: begin c = yr; s = -xr; end
    endcase
  endfunction

  // Corner position (x, y, z) of ring row, column col, half-unit sphere.
  function automatic void sphere_vertex(int row, int col, int r, int d,
                                        output logic [15:0] vx, output logic [15:0] vy,
                                        output logic [15:0] vz);
    longint unsigned cdiv, rdiv;
    logic [31:0] pa, pb;
    longint ca, sa, cb, sb;
    cdiv = r;
    rdiv = 2 * (d - 1);
    pa = 32'(((longint'(col) << 32) + cdiv / 2) / cdiv);
    pb = 32'(((longint'(row) << 32) + rdiv / 2) / rdiv);
    cordic_sincos(pa, ca, sa);
    cordic_sincos(pb, cb, sb);
    vx = 16'(sra(sa * sb + (64'sd1 <<< 46), 47));
    vy = 16'(sra(cb + (64'sd1 <<< 16), 17));
    vz = 16'(sra(ca * sb + (64'sd1 <<< 46), 47));
  endfunction

  function automatic face_t predict_face(logic [16:0] n);
    face_t f;
    int r, d, k, row, col, coln;
    int mesh, total;
    r = (around_q < 3) ? 3 : (around_q > MaxRes) ? MaxRes : around_q;
    d = (down_q < 2) ? 2 : (down_q > MaxRes) ? MaxRes : down_q;
    mesh = 2 * r * (d - 1);
    total = 2 * r * d;
    if (n < mesh) begin
      k = n >> 1;
      row = k / r;
      col = k % r;
      coln = (col + 1) % r;
      f.status = usf_pkg::FaceMesh;
      if (!n[0]) begin
        sphere_vertex(row, col, r, d, f.coord[8], f.coord[7], f.coord[6]);
        sphere_vertex(row + 1, col, r, d, f.coord[5], f.coord[4], f.coord[3]);
        sphere_vertex(row, coln, r, d, f.coord[2], f.coord[1], f.coord[0]);
      end else begin
        sphere_vertex(row, coln, r, d, f.coord[8], f.coord[7], f.coord[6]);
        sphere_vertex(row + 1, col, r, d, f.coord[5], f.coord[4], f.coord[3]);
        sphere_vertex(row + 1, coln, r, d, f.coord[2], f.coord[1], f.coord[0]);
      end
    end else if (n < total) begin
      f.status = usf_pkg::FaceFiller;
      for (int m = 0; m < 9; m++) f.coord[m] = usf_pkg::UnitOut;
    end else begin
      f.status = usf_pkg::FaceOutOfRange;
      f.coord = '0;
    end
    return f;
  endfunction

  // Driver: one request per acceptance, random gaps between them.
  // The head of pending_faces stays queued until it is accepted.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) void'(pending_faces.pop_front());
        if (pending_faces.size() != 0 && !hold_tx &&
            $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          face_number <= pending_faces[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Prediction happens at acceptance so it sees the live settings.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_faces.insert(expected_faces.size(), predict_face(face_number));
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    face_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.status = usf_pkg::face_status_e'(face_status);
      got.coord = {fx, fy, fz, sx, sy, sz, tx, ty, tz};
      if (expected_faces.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_faces.pop_front();
        if (got.status != want.status) begin
          $display("%0t: face_status expected %0d actual %0d", $time, want.status,
                   got.status);
          errors++;
        end
        for (int m = 8; m >= 0; m--)
          if (got.coord[m] != want.coord[m]) begin
            $display("%0t: coord %0d expected %0d actual %0d", $time, 8 - m,
                     $signed(want.coord[m]), $signed(got.coord[m]));
            errors++;
          end
        if (want.status == usf_pkg::FaceFiller) filler_seen++;
        if (want.status == usf_pkg::FaceOutOfRange) range_seen++;
        faces_checked++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_face(logic [16:0] n);
    pending_faces.insert(pending_faces.size(), n);
  endtask

  task automatic wait_idle();
    while (pending_faces.size() != 0 || in_valid || expected_faces.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_setting(usf_pkg::cfg_reg_e idx, logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == usf_pkg::CfgResAround) around_q = value;
    else if (idx == usf_pkg::CfgResDown) down_q = value;
  endtask

  // Random batch: mostly mesh faces, some filler and out-of-range indices.
  task automatic queue_random(int count);
    int r, d, total, sel;
    r = (around_q < 3) ? 3 : (around_q > MaxRes) ? MaxRes : around_q;
    d = (down_q < 2) ? 2 : (down_q > MaxRes) ? MaxRes : down_q;
    total = 2 * r * d;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 75) queue_face(17'($urandom_range(2 * r * (d - 1) - 1)));
      else if (sel < 87) queue_face(17'($urandom_range(total - 1, 2 * r * (d - 1))));
      else if (sel < 95 && total < 131072)
        queue_face(17'($urandom_range(131071, total)));
      else queue_face(17'($urandom));
    end
  endtask

  initial begin
    logic [8:0] arounds[6] = '{9'd16, 9'd3, 9'd256, 9'd0, 9'd511, 9'd7};
    logic [8:0] downs[6] = '{9'd16, 9'd2, 9'd256, 9'd511, 9'd0, 9'd5};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, field extremes, both parities, filler, range.
    foreach (arounds[p]) begin
      if (p > 0) begin
        write_setting(usf_pkg::CfgResAround, arounds[p]);
        write_setting(usf_pkg::CfgResDown, downs[p]);
        write_setting(usf_pkg::cfg_reg_e'(2'd3), 9'h1ff);   // beyond the map, ignored
      end
      if (p == 0) begin
        queue_face(17'd0);
        queue_face(17'd1);
        queue_face(17'd31);
        queue_face(17'd479);
        queue_face(17'd480);
        queue_face(17'd511);
        queue_face(17'd512);
        queue_face(17'd131071);
        queue_face(17'h15555);
        queue_face(17'h0aaaa);
        wait_idle();
      end
      if (p < 2) begin
        in_idle_pct = 30; out_stall_pct = 81;
      end else if (p < 4) begin
        in_idle_pct = 81; out_stall_pct = 30;
      end else begin
        in_idle_pct = 0; out_stall_pct = 0;
      end
      queue_random(150);
      // Hold off mid-phase until the pipeline has emptied.
      while (pending_faces.size() > 75) @(posedge clk);
      hold_tx = 1'b1;
      while (expected_faces.size() != 0 || in_valid) @(posedge clk);
      hold_tx = 1'b0;
      wait_idle();
    end

    $display("checked %0d faces over %0d resolution settings (%0d filler, %0d out of range)",
             faces_checked, 6, filler_seen, range_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/usf_pkg.sv
design/usf_div.sv
design/usf_cordic.sv
design/usf_front.sv
design/usf_fifo.sv
design/usf_back.sv
design/uv_sphere_face_generator.sv
sim/tb_top.sv
